FILE: sv/rcrbs_pkg.sv
// ----------------------------------------------------------------------------
// rcrbs_pkg
// Shared types and constants for the RC rise-time button scanner.
// ----------------------------------------------------------------------------
package rcrbs_pkg;

    localparam int unsigned MASK_BITS  = 3;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX     = 8'd255;
    localparam logic [COUNT_W-1:0] THRESH_RESET  = 8'd120;
    localparam logic [COUNT_W-1:0] SAMPLES_RESET = 8'd255;

    localparam logic [CFG_IDX_W-1:0] REG_RISE_THRESHOLD   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_SCAN = 1'd1;

    typedef struct packed {
        logic                 drive_high;
        logic                 report_valid;
        logic [MASK_BITS-1:0] report_mask;
    } res_t;

    function automatic logic [1:0] popcount3(input logic [MASK_BITS-1:0] m);
        popcount3 = {1'b0, m[0]} + {1'b0, m[1]} + {1'b0, m[2]};
    endfunction

endpackage

FILE: sv/rc_rise_button_scanner.sv
// ----------------------------------------------------------------------------
// rc_rise_button_scanner
// RC rise-time button scanner: one tick request in, one result request out.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_ready  | pin_levels
//   out     | out_valid / out_ready| drive_high, report_valid, report_mask
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One request per cycle while in_ready is high; input then result register.
// Tick logic is a single pass of counter increment, compare and popcount.
// in_ready drops only while both the input and result registers are full and
// out_ready is low. cfg_ready is always high.
// Reset: threshold 120, samples per scan 255, scan state and valids cleared.
// ----------------------------------------------------------------------------
module rc_rise_button_scanner
    import rcrbs_pkg::*;
#(
    parameter int unsigned BUTTONS = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [MASK_BITS-1:0]  pin_levels,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  drive_high,
    output logic                  report_valid,
    output logic [MASK_BITS-1:0]  report_mask,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic                 in_vld_reg;
    logic                 in_vld_next;
    logic [MASK_BITS-1:0] pins_reg;
    logic                 out_vld_reg;
    logic                 out_vld_next;
    res_t                 res_reg;
    res_t                 res_now;
    logic [COUNT_W-1:0]   thresh_reg;
    logic [COUNT_W-1:0]   samples_reg;
    logic                 advance;
    logic                 in_fire;

    assign advance   = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !in_vld_reg || advance;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_fire)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    rcrbs_scan #(
        .BUTTONS (BUTTONS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .pins      (pins_reg),
        .threshold (thresh_reg),
        .samples   (samples_reg),
        .result    (res_now)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            thresh_reg  <= THRESH_RESET;
            samples_reg <= SAMPLES_RESET;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_RISE_THRESHOLD:   thresh_reg  <= cfg_data;
                    REG_SAMPLES_PER_SCAN: samples_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pins_reg <= pin_levels;
        end
        if (advance)
        begin
            res_reg <= res_now;
        end
    end

    assign out_valid    = out_vld_reg;
    assign drive_high   = res_reg.drive_high;
    assign report_valid = res_reg.report_valid;
    assign report_mask  = res_reg.report_mask;

endmodule

FILE: sv/rcrbs_scan.sv
// ----------------------------------------------------------------------------
// rcrbs_scan
// Scan state (tick index, slow-rise counters, last mask, report block) and
// the single-pass tick logic that produces one result per request.
// ----------------------------------------------------------------------------
module rcrbs_scan
    import rcrbs_pkg::*;
#(
    parameter int unsigned BUTTONS = 3
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [MASK_BITS-1:0] pins,
    input  logic [COUNT_W-1:0]   threshold,
    input  logic [COUNT_W-1:0]   samples,
    output res_t                 result
);

    logic [COUNT_W-1:0]   tick_reg;
    logic [COUNT_W-1:0]   tick_next;
    logic [COUNT_W-1:0]   cnt_reg  [BUTTONS];
    logic [COUNT_W-1:0]   cnt_next [BUTTONS];
    logic [COUNT_W-1:0]   cnt_inc  [BUTTONS];
    logic [MASK_BITS-1:0] last_mask_reg;
    logic [MASK_BITS-1:0] last_mask_next;
    logic                 blocked_reg;
    logic                 blocked_next;

    logic                 first_tick;
    logic [COUNT_W-1:0]   tick_inc;
    logic                 scan_end;
    logic [MASK_BITS-1:0] mask;
    logic                 fewer;

    assign first_tick = (tick_reg == '0);
    assign tick_inc   = (tick_reg != COUNT_MAX) ? tick_reg + 1'b1 : tick_reg;
    assign scan_end   = !first_tick && (tick_inc >= samples);

    for (genvar i = 0; i < BUTTONS; i++) begin : g_btn
        logic pin_high;
        if (i < MASK_BITS) begin : g_pin
            assign pin_high = pins[i];
        end
        else begin : g_nopin
            assign pin_high = 1'b0;
        end
        assign cnt_inc[i] = (!pin_high && cnt_reg[i] != COUNT_MAX)
                            ? cnt_reg[i] + 1'b1 : cnt_reg[i];
        assign cnt_next[i] = (first_tick || scan_end) ? '0 : cnt_inc[i];
    end

    for (genvar i = 0; i < MASK_BITS; i++) begin : g_mask
        if (i < BUTTONS) begin : g_on
            assign mask[i] = (cnt_inc[i] > threshold);
        end
        else begin : g_off
            assign mask[i] = 1'b0;
        end
    end

    assign fewer = (popcount3(mask) < popcount3(last_mask_reg));

    always_comb
    begin
        tick_next           = tick_reg;
        last_mask_next      = last_mask_reg;
        blocked_next        = blocked_reg;
        result.drive_high   = 1'b1;
        result.report_valid = 1'b0;
        result.report_mask  = '0;
        if (first_tick)
        begin
            tick_next = 8'd1;
        end
        else if (scan_end)
        begin
            tick_next         = '0;
            last_mask_next    = mask;
            result.drive_high = 1'b0;
            if (fewer)
            begin
                if (!blocked_reg)
                begin
                    result.report_valid = 1'b1;
                    result.report_mask  = mask;
                    blocked_next        = 1'b1;
                end
                if (mask == '0)
                begin
                    blocked_next = 1'b0;
                end
            end
        end
        else
        begin
            tick_next = tick_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            last_mask_reg <= '0;
            blocked_reg   <= 1'b0;
            for (int i = 0; i < BUTTONS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            tick_reg      <= tick_next;
            last_mask_reg <= last_mask_next;
            blocked_reg   <= blocked_next;
            for (int i = 0; i < BUTTONS; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

endmodule

FILE: sv/rcrbs_checker.sv
// ----------------------------------------------------------------------------
// rcrbs_checker
// Port-level checks for the RC rise-time button scanner.
// ----------------------------------------------------------------------------
module rcrbs_checker
    import rcrbs_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 drive_high,
    input logic                 report_valid,
    input logic [MASK_BITS-1:0] report_mask
);

    logic prev_low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_low_reg <= 1'b0;
        end
        else if (out_valid && out_ready)
        begin
            prev_low_reg <= !drive_high;
        end
    end

    // a report only comes with the end of a scan
    a_report_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && report_valid |-> !drive_high)
        else $error("report without scan end");

    a_mask_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !report_valid |-> report_mask == '0)
        else $error("mask set without report");

    // the tick after a scan end starts a new scan
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && prev_low_reg |-> drive_high)
        else $error("two scan ends in a row");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive_high)
        && $stable(report_valid) && $stable(report_mask))
        else $error("stalled result changed");

endmodule

bind rc_rise_button_scanner rcrbs_checker u_rcrbs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .drive_high   (drive_high),
    .report_valid (report_valid),
    .report_mask  (report_mask)
);

FILE: tb/sv/rise_scan_checker.sv
// ----------------------------------------------------------------------------
// rise_scan_checker
// Watches the tick, result and register channels of the button scanner,
// predicts the result of every accepted tick request and compares them in
// order. Hands the mismatch count, the open tick count and the number of
// release reports seen to the testbench top.
// ----------------------------------------------------------------------------
module rise_scan_checker
    import rcrbs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [MASK_BITS-1:0]  pin_levels,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  drive_high,
    input  logic                  report_valid,
    input  logic [MASK_BITS-1:0]  report_mask,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding,
    output int                    releases
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [CFG_DATA_W-1:0] rise_limit;
    logic [CFG_DATA_W-1:0] scan_length;
    logic [COUNT_W-1:0]    scan_tick;
    logic [COUNT_W-1:0]    slow_cnt [MASK_BITS];
    logic [MASK_BITS-1:0]  prev_mask;
    logic                  release_blocked;
    res_t                  tick_results_q [$];

    task automatic advance_scan(input logic [MASK_BITS-1:0] pins);
        res_t                 r;
        logic [MASK_BITS-1:0] mask;
        int                   new_cnt;
        int                   old_cnt;
        r.drive_high   = 1'b1;
        r.report_valid = 1'b0;
        r.report_mask  = '0;
        if (scan_tick == '0) begin
            scan_tick = 8'd1;
        end
        else begin
            if (scan_tick != COUNT_MAX)
                scan_tick = scan_tick + 1'b1;
            for (int b = 0; b < MASK_BITS; b++)
                if (!pins[b] && slow_cnt[b] != COUNT_MAX)
                    slow_cnt[b] = slow_cnt[b] + 1'b1;
            if (scan_tick >= scan_length) begin
                mask    = '0;
                new_cnt = 0;
                old_cnt = 0;
                for (int b = 0; b < MASK_BITS; b++) begin
                    mask[b] = (slow_cnt[b] > rise_limit);
                    new_cnt += mask[b];
                    old_cnt += prev_mask[b];
                end
                if (new_cnt < old_cnt) begin
                    if (!release_blocked) begin
                        r.report_valid  = 1'b1;
                        r.report_mask   = mask;
                        release_blocked = 1'b1;
                    end
                    if (new_cnt == 0)
                        release_blocked = 1'b0;
                end
                prev_mask = mask;
                for (int b = 0; b < MASK_BITS; b++)
                    slow_cnt[b] = '0;
                scan_tick    = '0;
                r.drive_high = 1'b0;
            end
        end
        tick_results_q.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want;
        if (!rst_n)
        begin
            rise_limit      = THRESH_RESET;
            scan_length     = SAMPLES_RESET;
            scan_tick       = '0;
            prev_mask       = '0;
            release_blocked = 1'b0;
            for (int b = 0; b < MASK_BITS; b++)
                slow_cnt[b] = '0;
            tick_results_q.delete();
            mismatches  = 0;
            outstanding = 0;
            releases    = 0;
        end
        else
        begin
            // results leave before this edge's tick request enters
            if (out_valid && out_ready)
            begin
                if (tick_results_q.size() == 0)
                begin
                    $error("result request with no tick pending");
                    mismatches++;
                end
                else
                begin
                    want = tick_results_q.pop_front();
                    if (drive_high !== want.drive_high)
                    begin
                        $error("drive_high: expected %0d, got %0d",
                               want.drive_high, drive_high);
                        mismatches++;
                    end
                    if (report_valid !== want.report_valid)
                    begin
                        $error("report_valid: expected %0d, got %0d",
                               want.report_valid, report_valid);
                        mismatches++;
                    end
                    if (report_mask !== want.report_mask)
                    begin
                        $error("report_mask: expected %0d, got %0d",
                               want.report_mask, report_mask);
                        mismatches++;
                    end
                    if (want.report_valid)
                        releases++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_RISE_THRESHOLD:   rise_limit  = cfg_data;
                    REG_SAMPLES_PER_SCAN: scan_length = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                advance_scan(pin_levels);
            outstanding = tick_results_q.size();
        end
    end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench top for the RC rise-time button scanner. Drives directed scans
// over the register extremes and release corner cases, then random scans
// shaped as press/release patterns under three back-pressure profiles.
// Checking is done by rise_scan_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rcrbs_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 2;
    localparam int SCANS       = 8;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [MASK_BITS-1:0]  pin_levels;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  drive_high;
    logic                  report_valid;
    logic [MASK_BITS-1:0]  report_mask;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int outstanding;
    int releases;
    int send_idle;
    int recv_idle;
    int ticks_sent;
    int stall_cycles;
    int scan_len;
    logic [MASK_BITS-1:0] press_plan;

    rc_rise_button_scanner dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pin_levels   (pin_levels),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .drive_high   (drive_high),
        .report_valid (report_valid),
        .report_mask  (report_mask),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    rise_scan_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pin_levels   (pin_levels),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .drive_high   (drive_high),
        .report_valid (report_valid),
        .report_mask  (report_mask),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .releases     (releases)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            stall_cycles = 0;
        end
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_tick(input logic [MASK_BITS-1:0] p);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        pin_levels <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        ticks_sent++;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        wait (outstanding == 0);
        @(negedge clk);
    endtask

    task automatic configure(input logic [7:0] thr, input logic [7:0] spp);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= REG_RISE_THRESHOLD;
        cfg_data  <= thr;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_index <= REG_SAMPLES_PER_SCAN;
        cfg_data  <= spp;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
        scan_len = (spp < 2) ? 2 : spp;
    endtask

    task automatic send_seq(input logic [47:0] seq, input int n);
        for (int i = 0; i < n; i++)
            send_tick(seq[3*(n-1-i) +: 3]);
    endtask

    // one scan; pressed buttons mostly read low, released ones mostly high
    task automatic send_scan(input logic [MASK_BITS-1:0] target, input bit shaped);
        logic [MASK_BITS-1:0] p;
        for (int t = 0; t < scan_len; t++)
        begin
            p = 3'($urandom_range(0, 7));
            if (t != 0 && shaped)
                for (int b = 0; b < MASK_BITS; b++)
                    p[b] = target[b] ? ($urandom_range(0, 9) == 0)
                                     : ($urandom_range(0, 9) != 0);
            send_tick(p);
        end
    endtask

    task automatic run_phase;
        int spp;
        int thr;
        int hold_at;
        spp = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        case ($urandom_range(0, 9))
            0:       thr = 0;
            1:       thr = 255;
            default: thr = $urandom_range(0, ((spp < 2) ? 2 : spp) - 2);
        endcase
        configure(8'(thr), 8'(spp));
        hold_at = $urandom_range(1, SCANS - 1);
        for (int s = 0; s < SCANS; s++)
        begin
            if (s == hold_at)
                drain();
            if ($urandom_range(0, 1))
                press_plan = press_plan & 3'($urandom_range(0, 7));
            else
                press_plan = 3'($urandom_range(0, 7));
            send_scan(press_plan, $urandom_range(0, 99) < 85);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        pin_levels   = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_RISE_THRESHOLD;
        cfg_data     = '0;
        send_idle    = 21;
        recv_idle    = 65;
        ticks_sent   = 0;
        stall_cycles = 0;
        scan_len     = 255;
        press_plan   = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // two-tick scans at threshold 0: mask is the inverse of the pins
        // sampled on the second tick; covers blocked and release-to-none
        configure(8'd0, 8'd0);
        send_seq({3'd7, 3'd0, 3'd0, 3'd4, 3'd5, 3'd6, 3'd2, 3'd7,
                  3'd1, 3'd0, 3'd3, 3'd7, 3'd6, 3'd3, 3'd0, 3'd1}, 16);
        configure(8'd255, 8'd1);
        send_seq(48'({3'd0, 3'd0, 3'd7, 3'd0}), 4);
        configure(8'd1, 8'd3);
        send_seq(48'({3'd5, 3'd0, 3'd0, 3'd2, 3'd7, 3'd7}), 6);

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle = (mode == 0) ? 21 : (mode == 1) ? 65 : 0;
            recv_idle = (mode == 0) ? 65 : (mode == 1) ? 21 : 0;
            for (int ph = 0; ph < PHASES; ph++)
                run_phase();
        end

        // longest scan at the reset settings: full press, then full release
        configure(THRESH_RESET, SAMPLES_RESET);
        send_scan(3'b111, 1'b1);
        send_scan(3'b000, 1'b1);

        drain();
        repeat (8) @(posedge clk);
        $display("covered %0d tick requests, %0d release reports checked,",
                 ticks_sent, releases);
        $display("thresholds 0..255, scan lengths 0..255, three back-pressure profiles");
        if (mismatches == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
sv/rcrbs_pkg.sv
sv/rcrbs_scan.sv
sv/rc_rise_button_scanner.sv
sv/rcrbs_checker.sv
tb/sv/rise_scan_checker.sv
tb/sv/tb.sv
